/* sv/assert_macros.svh */
// Assertion macros for the sensor reply deframer, included by sensor_reply_deframer_unit.
// Depends on nothing; each macro takes its clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in sensor reply deframer");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in sensor reply deframer");

`endif

/* sv/srd_pkg.sv */
// Shared constants and types for the sensor reply deframer.
// Used by srd_frame_tracker and sensor_reply_deframer_unit; depends on nothing.
package srd_pkg;

    // Frame markers and the command byte after reset.
    localparam logic [7:0] START_BYTE   = 8'hFF;
    localparam logic [7:0] CMD_RESET    = 8'h86;

    // Frame position codes: hunting, the two ppm bytes, and the checksum byte.
    localparam logic [2:0] POS_HUNT     = 3'd0;
    localparam logic [2:0] POS_PPM_HIGH = 3'd1;
    localparam logic [2:0] POS_PPM_LOW  = 3'd2;
    localparam logic [2:0] POS_CHECK    = 3'd7;

    // One result as it leaves the frame tracker.
    typedef struct packed {
        logic        fire;
        logic [15:0] co2_ppm;
        logic        checksum_ok;
    } t_srd_result;

    // Tracker status seen by the top level for flow control and checking.
    typedef struct packed {
        logic at_check;
        logic hunting;
        logic sum_zero;
    } t_srd_status;

endpackage

/* sv/srd_frame_tracker.sv */
// Frame tracker: hunts for the start and command bytes, sums the frame and
// checks the negated-sum checksum. Depends on srd_pkg.
module srd_frame_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    output srd_pkg::t_srd_result  o_result,
    output srd_pkg::t_srd_status  o_status
);
    import srd_pkg::*;

    logic [7:0]  r_cmd;
    logic [7:0]  r_prev;
    logic [2:0]  r_pos;
    logic [7:0]  r_sum;
    logic [15:0] r_ppm;

    logic [7:0]  n_prev;
    logic [2:0]  n_pos;
    logic [7:0]  n_sum;
    logic [15:0] n_ppm;
    logic        w_header_hit;
    logic [7:0]  w_expect;

    assign w_header_hit = (r_prev == START_BYTE) && (i_rx_byte == r_cmd);
    assign w_expect     = ~r_sum + 8'd1;

    // Next state for one accepted word.
    always_comb begin
        n_prev = r_prev;
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_ppm  = r_ppm;
        if (i_accept) begin
            case (r_pos)
                POS_HUNT: begin
                    if (w_header_hit) begin
                        n_sum = i_rx_byte;
                        n_pos = POS_PPM_HIGH;
                    end else begin
                        n_prev = i_rx_byte;
                    end
                end
                POS_CHECK: begin
                    n_pos  = POS_HUNT;
                    n_prev = 8'd0;
                    n_sum  = 8'd0;
                end
                default: begin
                    if (r_pos == POS_PPM_HIGH) begin
                        n_ppm[15:8] = i_rx_byte;
                    end
                    if (r_pos == POS_PPM_LOW) begin
                        n_ppm[7:0] = i_rx_byte;
                    end
                    n_sum = r_sum + i_rx_byte;
                    n_pos = r_pos + 3'd1;
                end
            endcase
        end
    end

    // Control state and the command register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= CMD_RESET;
            r_prev <= 8'd0;
            r_pos  <= POS_HUNT;
            r_sum  <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_cmd <= i_cfg_wdata;
            end
            r_prev <= n_prev;
            r_pos  <= n_pos;
            r_sum  <= n_sum;
        end
    end

    // The ppm capture is always written before it is read.
    always_ff @(posedge i_clk) begin
        r_ppm <= n_ppm;
    end

    // A result comes with the checksum word.
    assign o_result.fire        = i_accept && (r_pos == POS_CHECK);
    assign o_result.co2_ppm     = r_ppm;
    assign o_result.checksum_ok = (i_rx_byte == w_expect);

    assign o_status.at_check = (r_pos == POS_CHECK);
    assign o_status.hunting  = (r_pos == POS_HUNT);
    assign o_status.sum_zero = (r_sum == 8'd0);

endmodule

/* sv/sensor_reply_deframer_unit.sv */
// Sensor reply deframer: one received byte per word in, one ppm result per frame out.
// The result is registered: it is valid in the cycle after the checksum word is accepted.
// Throughput: one word per cycle; only a checksum word waits, while a held result is not taken.
// The output register frees the input side for all other words.
// Reset (synchronous, active low) returns to hunting and sets the command byte to 0x86.
module sensor_reply_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] co2_ppm
    output logic        o_m_tuser    // [0] checksum_ok
);
    import srd_pkg::*;

    `include "assert_macros.svh"

    t_srd_result w_result;
    t_srd_status w_status;
    logic        w_accept;

    logic        r_m_valid;
    logic        n_m_valid;
    logic [15:0] r_m_ppm;
    logic        r_m_ok;

    // Only the checksum word needs room in the output register.
    assign o_s_tready = !w_status.at_check || !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    srd_frame_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_rx_byte   (i_s_tdata),
        .o_result    (w_result),
        .o_status    (w_status)
    );

    // Output register valid flag.
    assign n_m_valid = w_result.fire || (r_m_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    // Output payload, loaded with each result.
    always_ff @(posedge i_clk) begin
        if (w_result.fire) begin
            r_m_ppm <= w_result.co2_ppm;
            r_m_ok  <= w_result.checksum_ok;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_ppm;
    assign o_m_tuser  = r_m_ok;

    // A new result only follows an accepted checksum word.
    `ASSERT_SAME(a_result_from_check, i_clk, i_rst_n, $rose(o_m_tvalid), $past(w_result.fire))
    // A checksum word is never taken while a held result is not draining.
    `ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_result.fire, !r_m_valid || i_m_tready)
    // The running sum stays cleared while hunting.
    `ASSERT_SAME(a_hunt_sum_zero, i_clk, i_rst_n, w_status.hunting, w_status.sum_zero)
    // After a checksum word the tracker is hunting again.
    `ASSERT_NEXT(a_back_to_hunt, i_clk, i_rst_n, w_result.fire, w_status.hunting)

endmodule
